@@ rtl/packed_element_unpacker_macros.svh @@
// ----------------------------------------------------------------------------
// packed_element_unpacker_macros.svh
// Assertion macros shared by the packed element unpacker RTL.
// ----------------------------------------------------------------------------
`ifndef PACKED_ELEMENT_UNPACKER_MACROS_SVH
`define PACKED_ELEMENT_UNPACKER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PEU_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("packed_element_unpacker: assertion failed");

// Next-cycle implication, disabled during reset
`define PEU_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("packed_element_unpacker: assertion failed");

`endif

@@ rtl/peu_pkg.sv @@
// ----------------------------------------------------------------------------
// peu_pkg
// Shared constants for the packed element unpacker: field widths, register
// indexes, result kinds and status codes.
// ----------------------------------------------------------------------------
package peu_pkg;

    // Field and register widths
    localparam int DATA_W     = 8;
    localparam int VALUE_W    = 12;
    localparam int CODE_W     = 2;
    localparam int MOD_W      = 13;
    localparam int TOTAL_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [MOD_W-1:0]   MODULUS_RESET = 13'd4096;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET   = 16'd1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_TOTAL = 1'b1;

    // Result kinds
    localparam logic KIND_ELEMENT = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Status codes
    localparam logic [CODE_W-1:0] ST_OK      = 2'd0;
    localparam logic [CODE_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [CODE_W-1:0] ST_LENGTH  = 2'd2;
    localparam logic [CODE_W-1:0] ST_PADDING = 2'd3;

endpackage

@@ rtl/packed_element_unpacker.sv @@
// ----------------------------------------------------------------------------
// packed_element_unpacker
// Decodes an LSB-first bit-packed array of ELEM_BITS-wide elements, checks
// range, length and padding, and closes each array with a status request.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_data_byte, s_final_byte
//  m_        out        m_valid / m_ready    m_item_kind, m_element_value,
//                                            m_status_code, m_run_end
//  cfg_      in         cfg_we (no wait)     cfg_index, cfg_data
//
//  One result request leaves per cycle from the output register while m_ready
//  allows. A byte is through once its results and range checks are made (one
//  extraction per cycle); the final byte also waits for its status request.
//  With 12-bit elements a byte yields at most one element, so while the output
//  is free bytes enter every cycle, except after a final byte with an element.
//  Synchronous active-low reset clears the decode state and output valid.
//  A stalled output holds the engine only when it has a result to hand over.
//
module packed_element_unpacker #(
    parameter int ELEM_BITS = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port
    input  logic                           cfg_we,
    input  logic [peu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [peu_pkg::CFG_DATA_W-1:0] cfg_data,
    // Byte input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [peu_pkg::DATA_W-1:0]     s_data_byte,
    input  logic                           s_final_byte,
    // Result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_item_kind,
    output logic [peu_pkg::VALUE_W-1:0]    m_element_value,
    output logic [peu_pkg::CODE_W-1:0]     m_status_code,
    output logic                           m_run_end
);

    import peu_pkg::*;

    `include "packed_element_unpacker_macros.svh"

    localparam int ACC_W   = ELEM_BITS + DATA_W - 1;
    localparam int NB_W    = $clog2(ELEM_BITS + 2 * DATA_W);
    localparam int CMP_W   = (ELEM_BITS > MOD_W) ? ELEM_BITS : MOD_W;
    localparam int EXP_MAX = (65535 * ELEM_BITS + 7) / 8;
    localparam int CNT_W   = $clog2(EXP_MAX + 2);
    localparam int PROD_W  = CNT_W + 3;

    // Configuration registers
    logic [MOD_W-1:0]   modulus_reg;
    logic [TOTAL_W-1:0] total_reg;

    // Decode state
    logic [ACC_W-1:0]   acc_reg,     acc_next;
    logic [NB_W-1:0]    nbits_reg,   nbits_next;
    logic [TOTAL_W-1:0] emitted_reg, emitted_next;
    logic [CNT_W-1:0]   bytes_reg,   bytes_next;
    logic [CODE_W-1:0]  err_reg,     err_next;
    logic               lastp_reg,   lastp_next;

    // Output register
    logic               m_valid_reg, m_valid_next;
    logic               kind_reg,    kind_next;
    logic [VALUE_W-1:0] value_reg,   value_next;
    logic [CODE_W-1:0]  code_reg,    code_next;
    logic               rend_reg,    rend_next;

    // Combinational decode signals
    logic [ELEM_BITS-1:0] cur_v;
    logic [ELEM_BITS-1:0] nxt_v;
    logic [ACC_W-1:0]     acc_shift;
    logic [NB_W-1:0]      nbits_after;
    logic                 cur_ok;
    logic                 nxt_ok;
    logic                 can_extract;
    logic                 cnt_more;
    logic                 remain;
    logic                 step_emit;
    logic                 step_go;
    logic                 out_free;
    logic                 accept;
    logic [PROD_W-1:0]    prod;
    logic [CNT_W-1:0]     expected;
    logic [CODE_W-1:0]    final_code;

    // Expected byte count: ceil(total * ELEM_BITS / 8)
    assign prod     = PROD_W'(total_reg) * PROD_W'(ELEM_BITS) + PROD_W'(7);
    assign expected = CNT_W'(prod >> 3);

    // Look at the current and the following element
    assign cur_v       = acc_reg[ELEM_BITS-1:0];
    assign acc_shift   = acc_reg >> ELEM_BITS;
    assign nxt_v       = acc_shift[ELEM_BITS-1:0];
    assign nbits_after = nbits_reg - NB_W'(ELEM_BITS);
    assign cur_ok      = CMP_W'(cur_v) < CMP_W'(modulus_reg);
    assign nxt_ok      = CMP_W'(nxt_v) < CMP_W'(modulus_reg);
    assign can_extract = (err_reg == ST_OK) && (emitted_reg < total_reg) &&
                         (nbits_reg >= NB_W'(ELEM_BITS));
    assign cnt_more    = ((TOTAL_W + 1)'(emitted_reg) + (TOTAL_W + 1)'(1) <
                          (TOTAL_W + 1)'(total_reg)) &&
                         (nbits_after >= NB_W'(ELEM_BITS));

    // Work left for the current byte after this cycle's step
    assign remain    = can_extract ? ((cur_ok && cnt_more) || lastp_reg) : 1'b0;
    assign step_emit = can_extract ? cur_ok : lastp_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign step_go   = !step_emit || out_free;
    assign s_ready   = step_go && !remain;
    assign accept    = s_valid && s_ready;

    // Final status, first error wins
    always_comb begin
        if (err_reg != ST_OK) begin
            final_code = err_reg;
        end else if (bytes_reg != expected) begin
            final_code = ST_LENGTH;
        end else if (acc_reg != '0) begin
            final_code = ST_PADDING;
        end else begin
            final_code = ST_OK;
        end
    end

    // Advance the decoder one step, then append an accepted byte
    always_comb begin
        acc_next     = acc_reg;
        nbits_next   = nbits_reg;
        emitted_next = emitted_reg;
        bytes_next   = bytes_reg;
        err_next     = err_reg;
        lastp_next   = lastp_reg;
        m_valid_next = m_valid_reg && !m_ready;
        kind_next    = kind_reg;
        value_next   = value_reg;
        code_next    = code_reg;
        rend_next    = rend_reg;

        if (step_go) begin
            if (can_extract) begin
                acc_next   = acc_shift;
                nbits_next = nbits_after;
                if (cur_ok) begin
                    emitted_next = emitted_reg + TOTAL_W'(1);
                    m_valid_next = 1'b1;
                    kind_next    = KIND_ELEMENT;
                    value_next   = VALUE_W'({{VALUE_W{1'b0}}, cur_v});
                    code_next    = ST_OK;
                    rend_next    = !(cnt_more && nxt_ok) && !lastp_reg;
                end else begin
                    err_next = ST_RANGE;
                end
            end else if (lastp_reg) begin
                m_valid_next = 1'b1;
                kind_next    = KIND_STATUS;
                value_next   = '0;
                code_next    = final_code;
                rend_next    = 1'b1;
                // Clear for the next array
                acc_next     = '0;
                nbits_next   = '0;
                emitted_next = '0;
                bytes_next   = '0;
                err_next     = ST_OK;
                lastp_next   = 1'b0;
            end
        end

        if (accept) begin
            if (bytes_next != '1) begin
                bytes_next = bytes_next + CNT_W'(1);
            end
            if ((err_next == ST_OK) && (emitted_next < total_reg)) begin
                acc_next   = acc_next | (ACC_W'(s_data_byte) << nbits_next);
                nbits_next = nbits_next + NB_W'(DATA_W);
            end
            lastp_next = s_final_byte;
        end
    end

    // Hold configuration and decode state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= MODULUS_RESET;
            total_reg   <= TOTAL_RESET;
            acc_reg     <= '0;
            nbits_reg   <= '0;
            emitted_reg <= '0;
            bytes_reg   <= '0;
            err_reg     <= ST_OK;
            lastp_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we && (cfg_index == REG_MODULUS)) begin
                modulus_reg <= cfg_data[MOD_W-1:0];
            end
            if (cfg_we && (cfg_index == REG_ELEMENT_TOTAL)) begin
                total_reg <= cfg_data[TOTAL_W-1:0];
            end
            acc_reg     <= acc_next;
            nbits_reg   <= nbits_next;
            emitted_reg <= emitted_next;
            bytes_reg   <= bytes_next;
            err_reg     <= err_next;
            lastp_reg   <= lastp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        code_reg  <= code_next;
        rend_reg  <= rend_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_item_kind     = kind_reg;
    assign m_element_value = value_reg;
    assign m_status_code   = code_reg;
    assign m_run_end       = rend_reg;

    // Checks
    `PEU_ASSERT_NOW(a_status_shape, m_valid && (m_item_kind == KIND_STATUS), m_run_end && (m_element_value == '0))
    `PEU_ASSERT_NOW(a_element_code, m_valid && (m_item_kind == KIND_ELEMENT), m_status_code == ST_OK)
    `PEU_ASSERT_NEXT(a_status_clears, step_go && !can_extract && lastp_reg, (emitted_reg == '0) && (err_reg == ST_OK))
    `PEU_ASSERT_NOW(a_no_accept_busy, s_valid && s_ready, !remain && step_go)

endmodule
